### rtl/aes256_pkg.sv
// aes-256 package: types, constants and round functions
`default_nettype none
package aes256_pkg;
   localparam int unsigned KeyWords   = 8;
   localparam int unsigned RoundCount = 14;
   localparam int unsigned SchedWords = 60;
   localparam int unsigned CsrIdxW    = 2;

   localparam logic [CsrIdxW-1:0] CSR_KEY_PART0 = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_PART1 = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_KEY_PART2 = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_KEY_PART3 = 2'd3;

   typedef logic [127:0] state_type;
   typedef logic [31:0]  word_type;

   typedef struct packed {
      logic      valid;
      state_type data;
   } stage_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic word_type sub_word(input word_type w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // byte i of the state sits at bits 127-8i
   function automatic state_type sub_shift(input state_type s);
      state_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(c*4+r) -: 8] = SBOX[s[127-8*((((c+r)%4)*4)+r) -: 8]];
         end
      end
      sub_shift = t;
   endfunction

   function automatic state_type mix_columns(input state_type s);
      state_type t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      mix_columns = t;
   endfunction
endpackage
`default_nettype wire

### rtl/aes256_key_sched.sv
// aes-256 key schedule: round keys rebuilt one word per cycle from the key registers
`default_nettype none
module aes256_key_sched (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_wr_idx,
   input  wire logic [63:0]               csr_wr_data,
   output logic                           keys_ready,
   output logic [aes256_pkg::RoundCount:0][127:0] sched_keys
);
   logic [3:0][63:0] key_ff;
   logic [59:0][31:0] words_ff;
   logic [5:0] cnt_ff, cnt_in;
   logic       ready_ff, ready_in;
   logic [7:0] rc_ff, rc_in;
   logic [31:0] t, w_new;
   logic        busy;

   assign busy = !ready_ff;

   always_comb begin
      t = words_ff[cnt_ff - 6'd1];
      if (cnt_ff[2:0] == 3'd0) begin
         t = aes256_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_ff, 24'h0};
      end else if (cnt_ff[2:0] == 3'd4) begin
         t = aes256_pkg::sub_word(t);
      end
      if (cnt_ff < 6'd8) begin
         w_new = cnt_ff[0] ? key_ff[cnt_ff[2:1]][31:0] : key_ff[cnt_ff[2:1]][63:32];
      end else begin
         w_new = words_ff[cnt_ff - 6'd8] ^ t;
      end
      cnt_in   = cnt_ff;
      ready_in = ready_ff;
      rc_in    = rc_ff;
      if (busy) begin
         if (cnt_ff == 6'd59) begin
            ready_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 6'd1;
         end
         if (cnt_ff >= 6'd8 && cnt_ff[2:0] == 3'd0) rc_in = aes256_pkg::xtime(rc_ff);
      end
      if (csr_wr_en) begin
         ready_in = 1'b0;
         cnt_in   = '0;
         rc_in    = 8'h01;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         cnt_ff   <= '0;
         ready_ff <= 1'b0;
         rc_ff    <= 8'h01;
      end else begin
         cnt_ff   <= cnt_in;
         ready_ff <= ready_in;
         rc_ff    <= rc_in;
         if (csr_wr_en) key_ff[csr_wr_idx] <= csr_wr_data;
      end
      if (busy && !csr_wr_en) words_ff[cnt_ff] <= w_new;
   end

   always_comb begin
      for (int r = 0; r <= aes256_pkg::RoundCount; r++) begin
         sched_keys[r] = {words_ff[4*r], words_ff[4*r+1], words_ff[4*r+2], words_ff[4*r+3]};
      end
   end

   assign keys_ready = ready_ff;

   a_ready_after_sweep: assert property (@(posedge clock) disable iff (reset)
      (busy && cnt_ff == 6'd59 && !csr_wr_en) |=> ready_ff)
      else $error("schedule did not complete");
   a_write_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (!ready_ff && cnt_ff == 6'd0))
      else $error("key write did not restart schedule");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 6'd59)
      else $error("schedule counter out of range");
endmodule
`default_nettype wire

### rtl/aes256_round_pipe.sv
// aes-256 round pipeline: one registered stage per round, stalls as a whole
`default_nettype none
module aes256_round_pipe (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire logic [127:0]           in_data,
   input  wire logic [aes256_pkg::RoundCount:0][127:0] sched_keys,
   output aes256_pkg::stage_type       out_stage
);
   aes256_pkg::stage_type stage_ff [aes256_pkg::RoundCount+1];
   aes256_pkg::stage_type stage_in [aes256_pkg::RoundCount+1];

   always_comb begin
      stage_in[0].valid = in_valid;
      stage_in[0].data  = in_data ^ sched_keys[0];
      for (int r = 1; r <= aes256_pkg::RoundCount; r++) begin
         stage_in[r].valid = stage_ff[r-1].valid;
         if (r == aes256_pkg::RoundCount) begin
            stage_in[r].data = aes256_pkg::sub_shift(stage_ff[r-1].data) ^ sched_keys[r];
         end else begin
            stage_in[r].data = aes256_pkg::mix_columns(aes256_pkg::sub_shift(stage_ff[r-1].data))
                               ^ sched_keys[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r <= aes256_pkg::RoundCount; r++) begin
         if (reset) begin
            stage_ff[r].valid <= 1'b0;
         end else if (advance) begin
            stage_ff[r].valid <= stage_in[r].valid;
         end
         if (advance) stage_ff[r].data <= stage_in[r].data;
      end
   end

   assign out_stage = stage_ff[aes256_pkg::RoundCount];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_stage))
      else $error("pipeline moved while stalled");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      advance |=> stage_ff[0].valid == $past(in_valid))
      else $error("valid lost at entry");
   a_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> stage_ff[1].valid == $past(stage_ff[0].valid))
      else $error("valid lost between rounds");
endmodule
`default_nettype wire

### rtl/aes256_block_encrypt_core.sv
// aes-256 block encrypt core: top level with key schedule and round pipeline
//
// input blocks arrive on req_ (tdata: block_high in [63:0], block_low in [127:64]);
// ciphertext leaves on rsp_ in the same layout. key bytes are written on the csr_
// port, indexes 0..3 for key_part0..3; the user must write them only while the core
// is idle, which the core does not enforce. after reset or any key write the schedule
// is rebuilt one word per cycle, and req_tready is low until it is complete.
// a block passes one register per round between accept and rsp_tvalid;
// one block per cycle is accepted while the result side keeps up and the keys are ready.
// when rsp_tready is low and the last stage holds a beat, the whole pipeline holds
// and req_tready drops; no beat is lost or repeated.
// reset clears all valid bits and starts the schedule under the all-zero key.
`default_nettype none
module aes256_block_encrypt_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_wr_idx,
   input  wire logic [63:0]  csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // block_high, block_low
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // cipher_high, cipher_low
);
   logic keys_ready;
   logic [aes256_pkg::RoundCount:0][127:0] sched_keys;
   aes256_pkg::stage_type out_stage;
   logic advance;

   aes256_key_sched u_sched (
      .clock, .reset, .csr_wr_en, .csr_wr_idx, .csr_wr_data,
      .keys_ready, .sched_keys
   );

   assign advance    = !out_stage.valid || rsp_tready;
   assign req_tready = advance && keys_ready;

   aes256_round_pipe u_pipe (
      .clock, .reset, .advance,
      .in_valid (req_tvalid && req_tready),
      .in_data  ({req_tdata[63:0], req_tdata[127:64]}),
      .sched_keys,
      .out_stage
   );

   assign rsp_tvalid = out_stage.valid;
   assign rsp_tdata  = {out_stage.data[63:0], out_stage.data[127:64]};
endmodule
`default_nettype wire

### bench/tb.sv
// testbench for the aes-256 block encrypt core: predicted ciphertext checked beat by beat
`timescale 1ns / 100ps
`default_nettype none
module tb;
   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } block_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_wr_idx = '0;
   logic [63:0]  csr_wr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;

   logic [63:0] key_reg [4];
   aes256_pkg::word_type sched [60];
   block_type   cipher_q [$];
   int          errors = 0;
   int          blocks_sent = 0;
   int          blocks_seen = 0;
   int          key_loads = 0;
   longint      cycles = 0;
   bit          calm = 1'b0;

   aes256_block_encrypt_core dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("aes256_block_encrypt_core regression: fail");
         $finish;
      end
   end

   function automatic logic [7:0] gdbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic aes256_pkg::word_type sbox_word(input aes256_pkg::word_type w);
      return {aes256_pkg::SBOX[w[31:24]], aes256_pkg::SBOX[w[23:16]],
              aes256_pkg::SBOX[w[15:8]], aes256_pkg::SBOX[w[7:0]]};
   endfunction

   task automatic expand_key();
      logic [7:0] rc;
      aes256_pkg::word_type t;
      rc = 8'h01;
      for (int i = 0; i < 8; i++)
         sched[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
      for (int i = 8; i < 60; i++) begin
         t = sched[i-1];
         if (i % 8 == 0) begin
            t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gdbl(rc);
         end else if (i % 8 == 4) begin
            t = sbox_word(t);
         end
         sched[i] = sched[i-8] ^ t;
      end
   endtask

   // s[i] is byte i of the block
   function automatic block_type encrypt(input block_type p);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      block_type  r;
      for (int i = 0; i < 8; i++) begin
         s[i] = p.high[63-8*i -: 8];
         s[i+8] = p.low[63-8*i -: 8];
      end
      for (int rnd = 0; rnd <= 14; rnd++) begin
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++)
               for (int rr = 0; rr < 4; rr++)
                  t[c*4+rr] = aes256_pkg::SBOX[s[((c+rr)%4)*4+rr]];
            s = t;
            if (rnd < 14) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
                  s[c*4]   = gdbl(a0) ^ gdbl(a1) ^ a1 ^ a2 ^ a3;
                  s[c*4+1] = a0 ^ gdbl(a1) ^ gdbl(a2) ^ a2 ^ a3;
                  s[c*4+2] = a0 ^ a1 ^ gdbl(a2) ^ gdbl(a3) ^ a3;
                  s[c*4+3] = gdbl(a0) ^ a0 ^ a1 ^ a2 ^ gdbl(a3);
               end
            end
         end
         for (int i = 0; i < 16; i++)
            s[i] ^= sched[rnd*4 + i/4][31-8*(i%4) -: 8];
      end
      for (int i = 0; i < 8; i++) begin
         r.high[63-8*i -: 8] = s[i];
         r.low[63-8*i -: 8] = s[i+8];
      end
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] edge64();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   // result side: random stalls, checks each beat
   initial begin
      block_type want, got;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[63:0], rsp_tdata[127:64]};
            blocks_seen++;
            if (cipher_q.size() == 0) begin
               $error("ciphertext beat with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               want = cipher_q.pop_front();
               if (got.high !== want.high) begin
                  $error("cipher_high expected %h actual %h", want.high, got.high);
                  errors++;
               end
               if (got.low !== want.low) begin
                  $error("cipher_low expected %h actual %h", want.low, got.low);
                  errors++;
               end
            end
         end
         if (calm || $urandom_range(0, 5) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock) begin
               if (rsp_tvalid && rsp_tready) ;
            end
         end
      end
   end

   // req_tvalid stays high between back-to-back beats; gaps and drain drop it
   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
      block_type b;
      b.high = hi;
      b.low = lo;
      if (!calm && $urandom_range(0, 6) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      cipher_q.push_back(encrypt(b));
      req_tvalid <= 1'b1;
      req_tdata <= {b.low, b.high};
      do @(posedge clock); while (!req_tready);
      blocks_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
      key_reg[idx] = val;
      csr_wr_en <= 1'b1;
      csr_wr_idx <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] k0, k1, k2, k3);
      drain();
      write_key(aes256_pkg::CSR_KEY_PART0, k0);
      write_key(aes256_pkg::CSR_KEY_PART1, k1);
      write_key(aes256_pkg::CSR_KEY_PART2, k2);
      write_key(aes256_pkg::CSR_KEY_PART3, k3);
      csr_wr_en <= 1'b0;
      expand_key();
      key_loads++;
   endtask

   task automatic test_zero_key();
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
   endtask

   task automatic test_standard_vector();
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block('0, '1);
      send_block('1, '0);
      load_key('1, '1, '1, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h8000000000000000, 64'h0000000000000001);
   endtask

   task automatic test_partial_update();
      drain();
      write_key(aes256_pkg::CSR_KEY_PART2, 64'h0123456789abcdef);
      csr_wr_en <= 1'b0;
      expand_key();
      send_block(64'hdeadbeefcafef00d, 64'h0f1e2d3c4b5a6978);
      send_block('0, '0);
   endtask

   task automatic test_random_blocks();
      for (int n = 0; n < 840; n++) begin
         if (n % 120 == 60)
            load_key(edge64(), edge64(), edge64(), edge64());
         if (n == 300)
            drain();
         if (n == 760)
            calm = 1'b1;
         send_block(n % 17 == 0 ? edge64() : rand64(), n % 13 == 0 ? edge64() : rand64());
      end
   endtask

   initial begin
      for (int i = 0; i < 4; i++)
         key_reg[i] = '0;
      expand_key();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_zero_key();
      test_standard_vector();
      test_partial_update();
      test_random_blocks();
      drain();
      $display("sent %0d blocks, checked %0d ciphertext beats", blocks_sent, blocks_seen);
      $display("covered %0d key loads, a partial key update and bursty stalls", key_loads);
      if (errors == 0) begin
         $display("aes256_block_encrypt_core regression: pass");
      end else begin
         $display("aes256_block_encrypt_core regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
rtl/aes256_pkg.sv
rtl/aes256_key_sched.sv
rtl/aes256_round_pipe.sv
rtl/aes256_block_encrypt_core.sv
bench/tb.sv
